@@ sv/bmpd_pkg.sv @@
package bmpd_pkg;

  localparam int unsigned MaxWidthDefault = 4096;
  localparam int unsigned MaxHeightDefault = 4096;
  localparam int unsigned PaletteDepthDefault = 256;
  localparam int unsigned HeaderBytes = 54;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_PRE    = 3'd1,
    PH_PIX    = 3'd2,
    PH_DONE   = 3'd3,
    PH_ERR    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FORMAT    = 3'd1,
    ST_DEPTH     = 3'd2,
    ST_COMPRESS  = 3'd3,
    ST_DIMENSION = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  localparam logic [1:0] DEPTH_PAL = 2'd0;
  localparam logic [1:0] DEPTH_24  = 2'd1;
  localparam logic [1:0] DEPTH_32  = 2'd2;

  // One result beat, before packing onto the output port.
  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] out_row;
    logic [11:0] out_column;
    logic        last_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [1:0]  source_depth;
    logic        was_top_down;
  } result_t;

  // Decoded header as seen by the byte engine.
  typedef struct packed {
    status_t     status;
    logic [12:0] width;
    logic [12:0] height;
    logic [1:0]  depth;
    logic        top_first;
    logic [8:0]  pal_count;
    logic [32:0] pal_base;
    logic [31:0] pixel_start;
    logic [14:0] row_pitch;
  } hdr_info_t;

endpackage

@@ sv/bmpd_header_check.sv @@
module bmpd_header_check #(
  parameter int unsigned MAX_WIDTH = bmpd_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bmpd_pkg::MaxHeightDefault,
  parameter int unsigned PALETTE_DEPTH = bmpd_pkg::PaletteDepthDefault
) (
  input  logic [7:0]          hdr [54],
  output bmpd_pkg::hdr_info_t info
);
  import bmpd_pkg::*;

  logic [31:0] dib, w, rh, mag, comp, off, used;
  logic [15:0] bpp;
  logic        top;
  logic [32:0] base;
  logic [32:0] diff;
  logic [31:0] entries;
  logic [17:0] bits;

  function automatic logic [31:0] le32(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
    return {d, c, b, a};
  endfunction

  always_comb begin
    dib  = le32(hdr[14], hdr[15], hdr[16], hdr[17]);
    w    = le32(hdr[18], hdr[19], hdr[20], hdr[21]);
    rh   = le32(hdr[22], hdr[23], hdr[24], hdr[25]);
    top  = rh[31];
    mag  = top ? (32'd0 - rh) : rh;
    bpp  = {hdr[29], hdr[28]};
    comp = le32(hdr[30], hdr[31], hdr[32], hdr[33]);
    off  = le32(hdr[10], hdr[11], hdr[12], hdr[13]);
    used = le32(hdr[46], hdr[47], hdr[48], hdr[49]);
    base = 33'd14 + {1'b0, dib};
    diff = {1'b0, off} - base;
    entries = {2'b00, diff[31:2]};
    if (used != 32'd0 && used < entries) begin
      entries = used;
    end
    bits = ({5'd0, w[12:0]} * {2'd0, bpp}) + 18'd31;

    info = '0;
    info.width = w[12:0];
    info.height = mag[12:0];
    info.top_first = top;
    info.pal_count = entries[8:0];
    info.pal_base = base;
    info.pixel_start = off;
    info.row_pitch = {bits[17:5], 2'b00};
    info.status = ST_OK;
    if (hdr[0] != 8'h42 || hdr[1] != 8'h4D || dib < 32'd40) begin
      info.status = ST_FORMAT;
    end else if (w == 32'd0 || w[31] || mag == 32'd0) begin
      info.status = ST_DIMENSION;
    end else if (bpp == 16'd8) begin
      info.depth = DEPTH_PAL;
      if (comp != 32'd0) begin
        info.status = ST_COMPRESS;
      end else if ({1'b0, off} <= base) begin
        info.status = ST_FORMAT;
      end else if (entries == 32'd0 || entries > 32'(PALETTE_DEPTH)) begin
        info.status = ST_FORMAT;
      end
    end else if (bpp == 16'd24) begin
      info.depth = DEPTH_24;
      if (comp != 32'd0) begin
        info.status = ST_COMPRESS;
      end
    end else if (bpp == 16'd32) begin
      info.depth = DEPTH_32;
      if (comp != 32'd0 && comp != 32'd3 && comp != 32'd6) begin
        info.status = ST_COMPRESS;
      end
    end else begin
      info.status = ST_DEPTH;
    end
    if (info.status == ST_OK) begin
      if (w > 32'(MAX_WIDTH) || mag > 32'(MAX_HEIGHT)) begin
        info.status = ST_DIMENSION;
      end else if (bpp != 16'd8 && off < 32'd54) begin
        info.status = ST_FORMAT;
      end
    end
  end

endmodule

@@ sv/bmpd_engine.sv @@
module bmpd_engine #(
  parameter int unsigned MAX_WIDTH = bmpd_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bmpd_pkg::MaxHeightDefault,
  parameter int unsigned PALETTE_DEPTH = bmpd_pkg::PaletteDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_eof,
  input  logic              out_ready,
  output logic              out_valid,
  output bmpd_pkg::result_t out_res
);
  import bmpd_pkg::*;

  localparam int unsigned PalAw = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // Stage 1: registered input beat.
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_eof;

  phase_t      phase, phase_next;
  logic [31:0] byte_position;
  logic [31:0] in_pos;
  logic [7:0]  header_store [54];
  hdr_info_t   hinfo, hreg;
  logic [11:0] column_count;
  logic [11:0] source_row_count;
  logic [14:0] row_byte_count;
  logic [1:0]  byte_in_pixel;
  logic [23:0] pixel_assembly;
  logic [23:0] palette_store [PALETTE_DEPTH];
  logic [PalAw-1:0] pal_idx;
  logic [23:0] pal_word;

  logic        advance;
  logic        res_valid;
  result_t     res;

  // Next-state variables.
  logic [11:0] col_n, row_n;
  logic [14:0] rbc_n;
  logic [1:0]  bip_n;
  logic [23:0] asm_n;
  logic        rearm;
  logic        pal_we;
  logic [7:0]  pal_wa;
  logic [1:0]  pal_k;
  logic [32:0] rel;

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
    if (advance) begin
      s1_byte <= in_byte;
      s1_eof <= in_eof;
    end
  end

  // File position of the byte now on the input; an end-of-file byte in stage 1
  // restarts the count at zero.
  assign in_pos = !s1_valid ? byte_position : (s1_eof ? 32'd0 : byte_position + 32'd1);

  // Header bytes are captured at input time so the check sees all 54.
  always_ff @(posedge clk) begin
    if (advance && in_valid && phase_next == PH_HEADER && in_pos < 32'd54) begin
      header_store[6'(in_pos)] <= in_byte;
    end
  end

  bmpd_header_check #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_check (
    .hdr(header_store),
    .info(hinfo)
  );

  // The palette is read as the byte enters stage 1, so its word is ready with it.
  always_comb begin
    pal_idx = PalAw'(in_byte);
    if ({1'b0, in_byte} >= hreg.pal_count) begin
      pal_idx = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pal_word <= palette_store[pal_idx];
    end
  end

  always_comb begin
    phase_next = phase;
    res_valid = 1'b0;
    res = '0;
    col_n = column_count;
    row_n = source_row_count;
    rbc_n = row_byte_count;
    bip_n = byte_in_pixel;
    asm_n = pixel_assembly;
    rearm = 1'b0;
    pal_we = 1'b0;
    rel = {1'b0, byte_position} - hreg.pal_base;
    pal_wa = rel[9:2];
    pal_k = rel[1:0];
    if (s1_valid) begin
      case (phase)
        PH_HEADER: begin
          if (byte_position >= 32'd53) begin
            res_valid = 1'b1;
            if (hinfo.status != ST_OK || s1_eof) begin
              res.kind = KIND_ERROR;
              res.status = (hinfo.status != ST_OK) ? hinfo.status : ST_TRUNCATED;
              phase_next = PH_ERR;
            end else begin
              res.kind = KIND_HEADER;
              res.image_width = hinfo.width;
              res.image_height = hinfo.height;
              res.source_depth = hinfo.depth;
              res.was_top_down = hinfo.top_first;
              phase_next = PH_PRE;
            end
          end
        end
        PH_PRE, PH_PIX: begin
          if (phase == PH_PIX || byte_position == hreg.pixel_start) begin
            logic done_px;
            done_px = 1'b0;
            phase_next = PH_PIX;
            if ({1'b0, column_count} < hreg.width) begin
              if (hreg.depth == DEPTH_PAL) begin
                asm_n = pal_word;
                done_px = 1'b1;
              end else begin
                case (byte_in_pixel)
                  2'd0: asm_n = {16'd0, s1_byte};
                  2'd1: asm_n = {pixel_assembly[23:16], s1_byte, pixel_assembly[7:0]};
                  2'd2: asm_n = {s1_byte, pixel_assembly[15:0]};
                  default: asm_n = pixel_assembly;
                endcase
                if ((hreg.depth == DEPTH_24 && byte_in_pixel == 2'd2) ||
                    byte_in_pixel == 2'd3) begin
                  bip_n = 2'd0;
                  done_px = 1'b1;
                end else begin
                  bip_n = byte_in_pixel + 2'd1;
                end
              end
              if (done_px) begin
                res_valid = 1'b1;
                res.kind = KIND_PIXEL;
                res.blue = asm_n[7:0];
                res.green = asm_n[15:8];
                res.red = asm_n[23:16];
                res.out_row = hreg.top_first ? source_row_count :
                              12'(hreg.height - 13'd1 - {1'b0, source_row_count});
                res.out_column = column_count;
                res.last_pixel = ({1'b0, column_count} == hreg.width - 13'd1) &&
                                 ({1'b0, source_row_count} == hreg.height - 13'd1);
                col_n = column_count + 12'd1;
              end
            end
            rbc_n = row_byte_count + 15'd1;
            if (rbc_n >= hreg.row_pitch) begin
              rbc_n = '0;
              col_n = '0;
              bip_n = '0;
              row_n = source_row_count + 12'd1;
              // Compared at 13 bits so a full 4096-row image still completes.
              if ({1'b0, source_row_count} + 13'd1 >= hreg.height) begin
                phase_next = PH_DONE;
              end
            end
          end else if (hreg.depth == DEPTH_PAL &&
                       {1'b0, byte_position} >= hreg.pal_base &&
                       rel < {22'd0, hreg.pal_count, 2'b00} &&
                       pal_k != 2'd3) begin
            pal_we = 1'b1;
          end
        end
        default: ;
      endcase
      if (s1_eof) begin
        if (phase_next != PH_DONE && phase_next != PH_ERR) begin
          res_valid = 1'b1;
          res = '0;
          res.kind = KIND_ERROR;
          res.status = ST_TRUNCATED;
        end
        rearm = 1'b1;
        phase_next = PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we && advance) begin
      case (pal_k)
        2'd0: palette_store[PalAw'(pal_wa)][7:0] <= s1_byte;
        2'd1: palette_store[PalAw'(pal_wa)][15:8] <= s1_byte;
        default: palette_store[PalAw'(pal_wa)][23:16] <= s1_byte;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      byte_position <= '0;
      column_count <= '0;
      source_row_count <= '0;
      row_byte_count <= '0;
      byte_in_pixel <= '0;
      pixel_assembly <= '0;
      hreg <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
      if (s1_valid) begin
        phase <= phase_next;
        if (rearm) begin
          byte_position <= '0;
          column_count <= '0;
          source_row_count <= '0;
          row_byte_count <= '0;
          byte_in_pixel <= '0;
          pixel_assembly <= '0;
        end else begin
          if (byte_position != 32'hFFFF_FFFF) begin
            byte_position <= byte_position + 32'd1;
          end
          column_count <= col_n;
          source_row_count <= row_n;
          row_byte_count <= rbc_n;
          byte_in_pixel <= bip_n;
          pixel_assembly <= asm_n;
        end
        if (phase == PH_HEADER && phase_next == PH_PRE) begin
          hreg <= hinfo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

endmodule

@@ sv/bmp_stream_to_bgr24_decoder_core.sv @@
// BMP stream decoder: takes a BMP file one byte per beat on the slave side,
// checks its 54-byte header, loads the palette of 8-bit files and emits one
// header beat followed by one BGR pixel beat per pixel, tagged with its
// top-down row and column. Errors and truncation give one error beat, after
// which bytes are dropped until the end-of-file byte; every end-of-file byte
// rearms the decoder for a new file. The decoder takes one byte every cycle:
// a byte passes an input register and the byte engine, and its result lands
// in an output register; a stalled master side only holds the pipeline
// while its result waits. The palette is a small memory written from the
// palette bytes and read once per pixel byte.
module bmp_stream_to_bgr24_decoder_core #(
  parameter int unsigned MAX_WIDTH = bmpd_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = bmpd_pkg::MaxHeightDefault,
  parameter int unsigned PALETTE_DEPTH = bmpd_pkg::PaletteDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], blue[10:3], green[18:11], red[26:19], out_row[38:27],
  // out_column[50:39], image_width[63:51], image_height[76:64],
  // source_depth[78:77], was_top_down[79]
  output logic [79:0] m_tdata,
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last_pixel
);
  import bmpd_pkg::*;

  result_t res;

  // The input register advances whenever the output register is free.
  assign s_tready = !m_tvalid || m_tready;

  bmpd_engine #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_byte(s_tdata),
    .in_eof(s_tlast),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_res(res)
  );

  assign m_tuser = res.kind;
  assign m_tlast = res.last_pixel;
  assign m_tdata = {res.was_top_down, res.source_depth, res.image_height,
                    res.image_width, res.out_column, res.out_row, res.red,
                    res.green, res.blue, res.status};

  // A waiting result is held until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A pixel beat never carries an error status.
  a_pix_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_PIXEL |-> m_tdata[2:0] == ST_OK)
    else $error("pixel beat with status");

  // The last-pixel flag only appears on pixel beats.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == KIND_PIXEL)
    else $error("last flag on non-pixel beat");

endmodule

@@ tb/sv/bmpd_checker.sv @@
`timescale 1ns / 100ps

// Watches both stream channels of the BMP decoder, runs its own decoder model
// on every accepted input beat and compares each accepted output beat with
// the oldest predicted beat.
module bmpd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  import bmpd_pkg::*;

  phase_t           ph;
  int unsigned      file_pos;
  logic [7:0]       hdr[54];
  logic [23:0]      pal[256];
  int unsigned      img_w, img_h, pal_cnt, pix_start, pal_base, stride;
  int unsigned      col, src_row, row_bytes, byte_in_px;
  logic [1:0]       depth;
  logic             top_first;
  logic [23:0]      px_acc;
  result_t          beat_q[$];
  int               errs;

  assign fail_count = errs;

  function automatic logic [31:0] le32(int at);
    return {hdr[at + 3], hdr[at + 2], hdr[at + 1], hdr[at]};
  endfunction

  task automatic rearm();
    ph = PH_HEADER;
    file_pos = 0;
    col = 0;
    src_row = 0;
    row_bytes = 0;
    byte_in_px = 0;
    px_acc = '0;
  endtask

  // Checks the stored header in the decoder's order and latches the image
  // geometry when it is accepted.
  function automatic status_t check_header();
    logic [31:0]     dib, w, rh, mag, bpp, comp, off, used;
    longint unsigned base, entries, bits;
    logic            top;
    entries = 0;
    if (hdr[0] != 8'h42 || hdr[1] != 8'h4D) return ST_FORMAT;
    dib = le32(14);
    if (dib < 40) return ST_FORMAT;
    w = le32(18);
    rh = le32(22);
    top = rh[31];
    mag = top ? 32'd0 - rh : rh;
    bpp = {16'd0, hdr[29], hdr[28]};
    comp = le32(30);
    off = le32(10);
    used = le32(46);
    if (w == 0 || w[31] || mag == 0) return ST_DIMENSION;
    base = 64'd14 + 64'(dib);
    if (bpp == 8) begin
      if (comp != 0) return ST_COMPRESS;
      if (64'(off) <= base) return ST_FORMAT;
      entries = (64'(off) - base) / 4;
      if (used > 0 && 64'(used) < entries) entries = 64'(used);
      if (entries == 0 || entries > 256) return ST_FORMAT;
      depth = DEPTH_PAL;
    end else if (bpp == 24) begin
      if (comp != 0) return ST_COMPRESS;
      depth = DEPTH_24;
    end else if (bpp == 32) begin
      if (comp != 0 && comp != 3 && comp != 6) return ST_COMPRESS;
      depth = DEPTH_32;
    end else begin
      return ST_DEPTH;
    end
    if (w > MaxWidthDefault || mag > MaxHeightDefault) return ST_DIMENSION;
    if (bpp != 8 && off < 54) return ST_FORMAT;
    bits = 64'(w) * bpp + 31;
    stride = 32'((bits / 32) * 4);
    img_w = w;
    img_h = mag;
    top_first = top;
    pal_cnt = 32'(entries);
    pal_base = 32'(base);
    pix_start = off;
    return ST_OK;
  endfunction

  task automatic pixel_byte(input logic [7:0] b, output bit hit, output result_t r);
    int unsigned nbytes, row;
    bit          done;
    hit = 0;
    r = '0;
    nbytes = (depth == DEPTH_PAL) ? 1 : (depth == DEPTH_24) ? 3 : 4;
    if (col < img_w) begin
      done = 0;
      if (depth == DEPTH_PAL) begin
        px_acc = pal[(b < pal_cnt) ? b : 8'd0];
        done = 1;
      end else begin
        if (byte_in_px == 0) px_acc = {16'd0, b};
        else if (byte_in_px < 3) px_acc[8 * byte_in_px +: 8] = b;
        byte_in_px++;
        if (byte_in_px >= nbytes) begin
          byte_in_px = 0;
          done = 1;
        end
      end
      if (done) begin
        row = top_first ? src_row : img_h - 1 - src_row;
        r.kind = KIND_PIXEL;
        r.blue = px_acc[7:0];
        r.green = px_acc[15:8];
        r.red = px_acc[23:16];
        r.out_row = row[11:0];
        r.out_column = col[11:0];
        r.last_pixel = (col == img_w - 1) && (src_row == img_h - 1);
        col++;
        hit = 1;
      end
    end
    row_bytes++;
    if (row_bytes >= stride) begin
      row_bytes = 0;
      col = 0;
      byte_in_px = 0;
      src_row++;
      if (src_row >= img_h) ph = PH_DONE;
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic eof);
    int unsigned pos, rel;
    status_t     st;
    result_t     r;
    bit          hit;
    hit = 0;
    r = '0;
    pos = file_pos;
    if (file_pos != 32'hFFFF_FFFF) file_pos++;
    case (ph)
      PH_HEADER: begin
        if (pos < 54) hdr[pos] = b;
        if (pos >= 53) begin
          st = check_header();
          if (st != ST_OK || eof) begin
            r.kind = KIND_ERROR;
            r.status = (st != ST_OK) ? st : ST_TRUNCATED;
            if (eof) rearm();
            else ph = PH_ERR;
          end else begin
            r.kind = KIND_HEADER;
            r.image_width = img_w[12:0];
            r.image_height = img_h[12:0];
            r.source_depth = depth;
            r.was_top_down = top_first;
            ph = PH_PRE;
          end
          beat_q.push_back(r);
          return;
        end
      end
      PH_PRE: begin
        if (pos == pix_start) begin
          ph = PH_PIX;
          pixel_byte(b, hit, r);
        end else if (depth == DEPTH_PAL && pos >= pal_base &&
                     64'(pos) < 64'(pal_base) + 4 * 64'(pal_cnt)) begin
          rel = pos - pal_base;
          if (rel[1:0] != 2'd3) pal[rel[9:2]][8 * rel[1:0] +: 8] = b;
        end
      end
      PH_PIX: pixel_byte(b, hit, r);
      default: ;
    endcase
    if (eof) begin
      // An end of file before the image is complete overrides this beat.
      if (ph != PH_DONE && ph != PH_ERR) begin
        r = '0;
        r.kind = KIND_ERROR;
        r.status = ST_TRUNCATED;
        hit = 1;
      end
      rearm();
    end
    if (hit) beat_q.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      foreach (hdr[i]) hdr[i] = '0;
      foreach (pal[i]) pal[i] = '0;
      img_w = 0;
      img_h = 0;
      depth = DEPTH_PAL;
      top_first = 0;
      pal_cnt = 0;
      pix_start = 0;
      pal_base = 0;
      stride = 0;
      rearm();
      beat_q.delete();
      errs = 0;
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got = {kind_t'(m_tuser), status_t'(m_tdata[2:0]), m_tdata[10:3], m_tdata[18:11],
               m_tdata[26:19], m_tdata[38:27], m_tdata[50:39], m_tlast, m_tdata[63:51],
               m_tdata[76:64], m_tdata[78:77], m_tdata[79]};
        if (beat_q.size() == 0) begin
          $display("%0t: unexpected output beat %p", $time, got);
          errs++;
        end else begin
          want = beat_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p", $time, want);
            $display("%0t:          actual   %p", $time, got);
            errs++;
          end
        end
      end
    end
    pending <= beat_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

// Top of the BMP decoder bench: builds BMP files byte by byte, sends them
// through the slave side under several idle patterns, throttles the master
// side and gives the verdict from the checker's failure count.
module tb_top;
  import bmpd_pkg::*;

  localparam int WatchLimit = 4000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int          fail_count;
  int          pending;
  int          send_idle = 0;
  int          recv_stall = 0;
  bit          hold = 0;
  int          sent_bytes = 0;
  int          quiet = 0;
  logic [7:0]  hb[54];
  logic [7:0]  file_q[$];

  always #4 clk = ~clk;

  bmp_stream_to_bgr24_decoder_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  bmpd_checker i_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .fail_count(fail_count), .pending(pending)
  );

  // The receiver stalls at random, or fully while a hold-off is running.
  always @(negedge clk) begin
    m_tready <= hold ? 1'b0 : ($urandom_range(99) >= recv_stall);
  end

  // The watchdog ends a run in which no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (!rst) begin
      quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
        $display("[bmp_stream_to_bgr24_decoder_core] ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic eof);
    @(negedge clk);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = b;
    s_tlast = eof;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
  endtask

  task automatic set32(int at, logic [31:0] v);
    {hb[at + 3], hb[at + 2], hb[at + 1], hb[at]} = v;
  endtask

  // Builds one file and sends it, the final byte flagged as end of file.
  // The pixel offset follows from the DIB size and palette, moved by gap;
  // cut keeps only that many bytes, and a header byte can be overwritten.
  task automatic send_file(int w, int h, int bpp, int comp, int dib, int npal, int used,
                           int gap, int extra, int cut, int bad_at, logic [7:0] bad_val);
    int              off, total, i;
    longint unsigned absh, plen;
    file_q.delete();
    absh = (h < 0) ? -longint'(h) : h;
    plen = ((64'(w) * bpp + 31) / 32) * 4 * absh;
    if (plen > 600) plen = 8;
    off = 14 + dib + ((bpp == 8) ? 4 * npal : 0) + gap;
    foreach (hb[k]) hb[k] = 8'($urandom_range(255));
    hb[0] = 8'h42;
    hb[1] = 8'h4D;
    set32(10, off);
    set32(14, dib);
    set32(18, w);
    set32(22, h);
    hb[26] = 8'd1;
    hb[27] = 8'd0;
    hb[28] = bpp[7:0];
    hb[29] = bpp[15:8];
    set32(30, comp);
    set32(46, used);
    if (bad_at >= 0) hb[bad_at] = bad_val;
    foreach (hb[k]) file_q.push_back(hb[k]);
    for (i = 54; i < off; i++) file_q.push_back(8'($urandom_range(255)));
    for (i = 0; i < plen; i++) begin
      // Palette indices mostly run from zero to one past the entry count, so both
      // sides of it are reached.
      if (bpp == 8 && $urandom_range(3) != 0) begin
        file_q.push_back(8'($urandom_range(npal + 1, 0)));
      end else begin
        file_q.push_back(8'($urandom_range(255)));
      end
    end
    for (i = 0; i < extra; i++) file_q.push_back(8'($urandom_range(255)));
    total = (cut > 0 && cut < file_q.size()) ? cut : file_q.size();
    for (i = 0; i < total; i++) send_byte(file_q[i], i == total - 1);
  endtask

  task automatic random_file();
    int      mode, w, h, bpp, comp, npal, used, len, i, sel;
    mode = $urandom_range(99);
    if (mode >= 90) begin
      // Pure noise, with end of file somewhere in or past the header.
      len = $urandom_range(80, 1);
      for (i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
      return;
    end
    w = $urandom_range(9, 1);
    h = $urandom_range(5, 1);
    if ($urandom_range(1)) h = -h;
    sel = $urandom_range(2);
    bpp = (sel == 0) ? 8 : (sel == 1) ? 24 : 32;
    comp = 0;
    if (bpp == 32) begin
      sel = $urandom_range(2);
      comp = (sel == 0) ? 0 : (sel == 1) ? 3 : 6;
    end
    npal = ($urandom_range(19) == 0) ? 256 : $urandom_range(16, 1);
    used = ($urandom_range(1) == 0) ? 0 : $urandom_range(npal + 2, 1);
    if (mode < 70) begin
      send_file(w, h, bpp, comp, ($urandom_range(3) == 0) ? 44 : 40, npal, used,
                $urandom_range(6), $urandom_range(1) ? $urandom_range(6) : 0, 0, -1, 0);
    end else if (mode < 80) begin
      send_file(w, h, bpp, comp, 40, npal, used, $urandom_range(3), 0,
                $urandom_range(54 + 4 * npal + 40, 1), -1, 0);
    end else begin
      send_file(w, h, bpp, comp, 40, npal, used, $urandom_range(3), 2, 0,
                $urandom_range(53), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int p, target;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed files: every depth, both row orders, and each header check.
    // Files that the header check turns away end with the last header byte.
    send_file(2, 2, 24, 0, 40, 0, 0, 0, 0, 0, -1, 0);
    send_file(3, -2, 32, 3, 40, 0, 0, 2, 3, 0, -1, 0);
    send_file(5, 1, 32, 6, 40, 0, 0, 0, 0, 0, -1, 0);
    send_file(4, 3, 8, 0, 40, 2, 0, 0, 1, 0, -1, 0);
    send_file(3, -2, 8, 0, 40, 8, 3, 4, 0, 0, -1, 0);
    send_file(4096, 1, 8, 0, 40, 1, 0, 0, 0, 0, -1, 0);
    send_file(1, -4096, 8, 0, 40, 1, 0, 0, 0, 0, -1, 0);
    send_file(2, 2, 24, 0, 40, 0, 0, 0, 0, 54, 0, 8'h41);
    send_file(2, 2, 24, 0, 39, 0, 0, 0, 0, 54, -1, 0);
    send_file(0, 2, 24, 0, 40, 0, 0, 0, 0, 54, -1, 0);
    send_file(-3, 2, 24, 0, 40, 0, 0, 0, 0, 54, -1, 0);
    send_file(2, 0, 24, 0, 40, 0, 0, 0, 0, 54, -1, 0);
    send_file(2, 32'h8000_0000, 24, 0, 40, 0, 0, 0, 0, 54, -1, 0);
    send_file(2, 2, 8, 1, 40, 4, 0, 0, 0, 54, -1, 0);
    send_file(2, 2, 8, 0, 40, 0, 0, 3, 0, 54, -1, 0);
    send_file(2, 2, 8, 0, 40, 257, 0, 0, 0, 54, -1, 0);
    send_file(2, 2, 24, 1, 40, 0, 0, 0, 0, 54, -1, 0);
    send_file(2, 2, 32, 2, 40, 0, 0, 0, 0, 54, -1, 0);
    send_file(2, 2, 16, 0, 40, 0, 0, 0, 0, 54, -1, 0);
    send_file(4097, 1, 24, 0, 40, 0, 0, 0, 0, 54, -1, 0);
    send_file(1, -4097, 24, 0, 40, 0, 0, 0, 0, 54, -1, 0);
    send_file(2, 2, 24, 0, 40, 0, 0, -1, 0, 54, -1, 0);
    send_file(2, 2, 24, 0, 40, 0, 0, 0, 0, 10, -1, 0);
    send_file(2, 2, 24, 0, 40, 0, 0, 0, 0, 54, -1, 0);

    // Random files under four idle patterns; the stalling phase also holds
    // the receiver off for a long stretch so the decoder backs up its input.
    target = sent_bytes;
    for (p = 0; p < 4; p++) begin
      send_idle = (p == 1 || p == 3) ? ((p == 1) ? 51 : 28) : 0;
      recv_stall = (p == 2) ? 51 : (p == 3) ? 28 : 0;
      if (p == 2) begin
        fork
          begin
            @(posedge clk);
            hold = 1;
            repeat (300) @(posedge clk);
            hold = 0;
          end
        join_none
      end
      target += 25;
      while (sent_bytes < target) random_file();
    end
    @(negedge clk);
    s_tvalid = 0;
    s_tlast = 0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[bmp_stream_to_bgr24_decoder_core] OK");
    end else begin
      $display("[bmp_stream_to_bgr24_decoder_core] ERROR");
    end
    $finish;
  end

endmodule

@@ bmp_stream_to_bgr24_decoder_core.f @@
sv/bmpd_pkg.sv
sv/bmpd_header_check.sv
sv/bmpd_engine.sv
sv/bmp_stream_to_bgr24_decoder_core.sv
tb/sv/bmpd_checker.sv
tb/sv/tb_top.sv
